// File: rtl/core/stx_pkg.sv
package stx_pkg;

  localparam int unsigned CharQDepth = 4;
  localparam int unsigned CharQIdxW  = 2;
  localparam int unsigned CharQCntW  = 3;

  localparam int unsigned CmdDepth   = 4;
  localparam int unsigned CmdIdxW    = 2;
  localparam int unsigned CmdCntW    = 3;

  localparam int unsigned ResDepth   = 2;
  localparam int unsigned ResIdxW    = 1;
  localparam int unsigned ResCntW    = 2;

  localparam logic [1:0] ACT_TICK     = 2'd0;
  localparam logic [1:0] ACT_RAW      = 2'd1;
  localparam logic [1:0] ACT_HEX_BYTE = 2'd2;
  localparam logic [1:0] ACT_HEX_WORD = 2'd3;

  localparam logic [3:0] LastBit  = 4'd9;
  localparam logic [3:0] DataBits = 4'd8;

  localparam logic [7:0] HexZero  = 8'h30;
  localparam logic [7:0] HexA     = 8'h41;
  localparam logic [3:0] HexTen   = 4'd10;

  localparam logic [15:0] BitPeriodReset = 16'd1;

  typedef logic [7:0] char_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] data;
  } in_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
  } out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                 send;
    char_t [3:0]          chars;
    logic [CharQCntW-1:0] rest;
  } cmd_t;

  function automatic char_t hex_digit(input logic [3:0] n);
    char_t d;
    if (n < HexTen) begin
      d = HexZero + {4'b0000, n};
    end else begin
      d = HexA + {4'b0000, n - HexTen};
    end
    return d;
  endfunction

endpackage

// File: rtl/core/stx_front.sv
module stx_front import stx_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  in_t  in_item,
  output logic cmd_valid,
  input  logic cmd_take,
  output cmd_t cmd
);

  cmd_t               mem_r [CmdDepth];
  logic [CmdIdxW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CmdIdxW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CmdCntW-1:0] cnt_r, cnt_nxt;
  logic               wr_en;
  logic               rd_en;
  cmd_t               dec;

  // classify the beat and expand hex digits
  always_comb begin
    dec       = '0;
    dec.send  = (in_item.action != ACT_TICK);
    case (in_item.action)
      ACT_RAW: begin
        dec.chars[0] = in_item.data[7:0];
        dec.rest     = CharQCntW'(0);
      end
      ACT_HEX_BYTE: begin
        dec.chars[0] = hex_digit(in_item.data[7:4]);
        dec.chars[1] = hex_digit(in_item.data[3:0]);
        dec.rest     = CharQCntW'(1);
      end
      ACT_HEX_WORD: begin
        dec.chars[0] = hex_digit(in_item.data[7:4]);
        dec.chars[1] = hex_digit(in_item.data[3:0]);
        dec.chars[2] = hex_digit(in_item.data[15:12]);
        dec.chars[3] = hex_digit(in_item.data[11:8]);
        dec.rest     = CharQCntW'(3);
      end
      default: begin
        dec.rest = CharQCntW'(0);
      end
    endcase
  end

  assign in_full   = (cnt_r == CmdCntW'(CmdDepth));
  assign wr_en     = in_push && !in_full;
  assign cmd_valid = (cnt_r != '0);
  assign rd_en     = cmd_take && cmd_valid;
  assign cmd       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + CmdIdxW'(1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + CmdIdxW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + CmdCntW'(wr_en) - CmdCntW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/stx_back.sv
module stx_back import stx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        cmd_valid,
  output logic        cmd_take,
  input  cmd_t        cmd,
  output logic        out_empty,
  input  logic        out_pop,
  output out_t        out_item
);

  logic [15:0]          bit_period_r;
  char_t                chq_r [CharQDepth];
  char_t                chq_nxt [CharQDepth];
  logic [CharQCntW-1:0] qcnt_r, qcnt_nxt;
  logic [CharQIdxW-1:0] head_r, head_nxt;
  char_t                shift_r, shift_nxt;
  logic [3:0]           bitpos_r, bitpos_nxt;
  logic [15:0]          tick_r, tick_nxt;
  logic                 in_frame_r, in_frame_nxt;
  logic                 line_r, line_nxt;

  out_t                 res_mem_r [ResDepth];
  logic [ResIdxW-1:0]   res_wr_r, res_rd_r;
  logic [ResCntW-1:0]   res_cnt_r;
  logic                 res_full;
  logic                 res_pop;
  out_t                 res;

  logic [15:0]          period;
  logic [16:0]          tick_sum;
  logic                 accepted;

  assign res_full  = (res_cnt_r == ResCntW'(ResDepth));
  assign out_empty = (res_cnt_r == '0);
  assign res_pop   = out_pop && !out_empty;
  assign cmd_take  = cmd_valid && !res_full;
  assign out_item  = res_mem_r[res_rd_r];

  assign period   = (bit_period_r == '0) ? 16'd1 : bit_period_r;
  assign tick_sum = {1'b0, tick_r} + 17'd1;

  always_comb begin
    chq_nxt      = chq_r;
    qcnt_nxt     = qcnt_r;
    head_nxt     = head_r;
    shift_nxt    = shift_r;
    bitpos_nxt   = bitpos_r;
    tick_nxt     = tick_r;
    in_frame_nxt = in_frame_r;
    line_nxt     = line_r;
    accepted     = 1'b0;
    if (cmd_take) begin
      if (!cmd.send) begin
        if (in_frame_r) begin
          if (tick_sum >= {1'b0, period}) begin
            tick_nxt = '0;
            if (bitpos_r >= LastBit) begin
              // frame done, start the next waiting char on this tick
              bitpos_nxt = '0;
              if (qcnt_r != '0) begin
                shift_nxt    = chq_r[head_r];
                head_nxt     = head_r + CharQIdxW'(1);
                qcnt_nxt     = qcnt_r - CharQCntW'(1);
                in_frame_nxt = 1'b1;
                line_nxt     = 1'b0;
              end else begin
                in_frame_nxt = 1'b0;
                line_nxt     = 1'b1;
              end
            end else begin
              bitpos_nxt = bitpos_r + 4'd1;
              if (bitpos_r < DataBits) begin
                line_nxt  = shift_r[0];
                shift_nxt = {1'b0, shift_r[7:1]};
              end else begin
                line_nxt = 1'b1;
              end
            end
          end else begin
            tick_nxt = tick_sum[15:0];
          end
        end
      end else if (!in_frame_r && (qcnt_r == '0)) begin
        accepted                           = 1'b1;
        chq_nxt[head_r + CharQIdxW'(1)]    = cmd.chars[1];
        chq_nxt[head_r + CharQIdxW'(2)]    = cmd.chars[2];
        chq_nxt[head_r + CharQIdxW'(3)]    = cmd.chars[3];
        shift_nxt                          = cmd.chars[0];
        head_nxt                           = head_r + CharQIdxW'(1);
        qcnt_nxt                           = cmd.rest;
        in_frame_nxt                       = 1'b1;
        bitpos_nxt                         = '0;
        tick_nxt                           = '0;
        line_nxt                           = 1'b0;
      end
    end
    res.line_level = line_nxt;
    res.busy_res   = in_frame_nxt || (qcnt_nxt != '0);
    res.accepted   = accepted;
  end

  always_ff @(posedge clk) begin
    chq_r <= chq_nxt;
    if (cmd_take) begin
      res_mem_r[res_wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= BitPeriodReset;
      qcnt_r       <= '0;
      head_r       <= '0;
      shift_r      <= '0;
      bitpos_r     <= '0;
      tick_r       <= '0;
      in_frame_r   <= 1'b0;
      line_r       <= 1'b1;
      res_wr_r     <= '0;
      res_rd_r     <= '0;
      res_cnt_r    <= '0;
    end else begin
      if (cfg_we) begin
        bit_period_r <= cfg_data;
      end
      qcnt_r     <= qcnt_nxt;
      head_r     <= head_nxt;
      shift_r    <= shift_nxt;
      bitpos_r   <= bitpos_nxt;
      tick_r     <= tick_nxt;
      in_frame_r <= in_frame_nxt;
      line_r     <= line_nxt;
      if (cmd_take) begin
        res_wr_r <= res_wr_r + ResIdxW'(1);
      end
      if (res_pop) begin
        res_rd_r <= res_rd_r + ResIdxW'(1);
      end
      res_cnt_r <= res_cnt_r + ResCntW'(cmd_take) - ResCntW'(res_pop);
    end
  end

endmodule

// File: rtl/core/serial_tx_with_hex_format_unit.sv
// 8N1 serial transmitter with hex formatting. Each input beat (tick, raw byte,
// byte as two hex digits, word as four hex digits) gives exactly one result
// beat with the line level, busy flag and whether a send was taken; a send
// is taken only while no frame runs and no character waits. One beat is
// taken per clock for as long as results are popped: a 4-deep command queue
// sits after the classifier and a 2-deep result queue after the transmitter,
// so a pushed beat passes through the command queue and then the result queue, and each side may stall on its own.
// bit_period is written through cfg_we/cfg_data and holds 1 after reset.
module serial_tx_with_hex_format_unit import stx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_t         in_item,
  output logic        out_empty,
  input  logic        out_pop,
  output out_t        out_item,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  stx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  stx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// File: rtl/core/stx_checker.sv
module stx_checker import stx_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic out_empty,
  input logic out_pop,
  input out_t out_item
);

  // reset leaves no result beat waiting
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result beat present after reset");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_item)))
    else $error("result beat changed while stalled");

  // a taken send starts a frame at once
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.accepted) |-> (out_item.busy_res && !out_item.line_level))
    else $error("accepted send without start bit");

  // idle line is high
  a_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.busy_res) |-> out_item.line_level)
    else $error("line low while idle");

endmodule

bind serial_tx_with_hex_format_unit stx_checker u_stx_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_item  (out_item)
);
